/* hw/rtl/swpr_pkg.sv */
// shared constants for the stereo width, pan and rotate mixer
package swpr_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int GUARD_BITS_DEF  = 4;

  localparam int GAIN_W   = 24;
  localparam int POS_W    = 18;
  localparam int COS_W    = 17;
  localparam int GAIN_FRAC = 20;
  localparam int POS_FRAC  = 16;
  localparam int POS_ONE   = 65536;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    REG_MID1  = 3'd0,
    REG_SIDE1 = 3'd1,
    REG_PAN1  = 3'd2,
    REG_COS   = 3'd3,
    REG_SIN   = 3'd4,
    REG_PAN2  = 3'd5,
    REG_MID2  = 3'd6,
    REG_SIDE2 = 3'd7
  } reg_index_t;

  localparam logic [GAIN_W-1:0] MID_GAIN_RST  = 24'd524288;
  localparam logic [GAIN_W-1:0] SIDE_GAIN_RST = 24'd1048576;
  localparam logic [POS_W-1:0]  PAN_RST       = 18'd0;
  localparam logic [COS_W-1:0]  COS_RST       = 17'd65536;
  localparam logic [POS_W-1:0]  SIN_RST       = 18'd0;

endpackage

/* hw/rtl/swpr_width.sv */
// mid/side width stage: saturated sum and difference, gain multiply, recombine
module swpr_width #(
  parameter int W = swpr_pkg::SAMPLE_BITS_DEF + swpr_pkg::GUARD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [W-1:0]           a_in,
  input  logic signed [W-1:0]           b_in,
  input  logic                          clip_in,
  input  logic [swpr_pkg::GAIN_W-1:0]   mid_gain,
  input  logic [swpr_pkg::GAIN_W-1:0]   side_gain,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [W-1:0]           a_out,
  output logic signed [W-1:0]           b_out,
  output logic                          clip_out
);

  localparam int EXT  = W + 6;
  localparam int PW   = W + swpr_pkg::GAIN_W + 1;
  localparam int SHW  = W + 5;

  function automatic logic [W:0] sat_ext(input logic signed [EXT-1:0] x);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &x[EXT-1:W-1];
    hi_zeros = ~|x[EXT-1:W-1];
    if (hi_ones || hi_zeros) begin
      sat_ext = {1'b0, x[W-1:0]};
    end else begin
      sat_ext = {1'b1, x[EXT-1], {(W-1){~x[EXT-1]}}};
    end
  endfunction

  logic v1, v2, v3;
  logic ready1, ready2, ready3;

  assign ready3   = !v3 || out_ready;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1;

  // stage 1: saturated sum and difference
  logic signed [W:0]   sum_raw, dif_raw;
  logic [W:0]          sum_sat, dif_sat;
  logic signed [W-1:0] s1_sum, s1_dif;
  logic                s1_clip;

  always_comb begin
    sum_raw = {a_in[W-1], a_in} + {b_in[W-1], b_in};
    dif_raw = {a_in[W-1], a_in} - {b_in[W-1], b_in};
    sum_sat = sat_ext({{(EXT-W-1){sum_raw[W]}}, sum_raw});
    dif_sat = sat_ext({{(EXT-W-1){dif_raw[W]}}, dif_raw});
  end

  // stage 2: gain multiply, floored
  logic signed [PW-1:0]  prod_m, prod_d;
  logic signed [SHW-1:0] s2_m, s2_d;
  logic                  s2_clip;

  always_comb begin
    prod_m = s1_sum * $signed({1'b0, mid_gain});
    prod_d = s1_dif * $signed({1'b0, side_gain});
  end

  // stage 3: recombine and saturate
  logic signed [EXT-1:0] lsum, ldif;
  logic [W:0]            l_sat, r_sat;

  always_comb begin
    lsum  = {s2_m[SHW-1], s2_m} + {s2_d[SHW-1], s2_d};
    ldif  = {s2_m[SHW-1], s2_m} - {s2_d[SHW-1], s2_d};
    l_sat = sat_ext(lsum);
    r_sat = sat_ext(ldif);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) v1 <= in_valid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      s1_sum  <= sum_sat[W-1:0];
      s1_dif  <= dif_sat[W-1:0];
      s1_clip <= clip_in | sum_sat[W] | dif_sat[W];
    end
    if (ready2 && v1) begin
      s2_m    <= SHW'(prod_m >>> swpr_pkg::GAIN_FRAC);
      s2_d    <= SHW'(prod_d >>> swpr_pkg::GAIN_FRAC);
      s2_clip <= s1_clip;
    end
    if (ready3 && v2) begin
      a_out    <= l_sat[W-1:0];
      b_out    <= r_sat[W-1:0];
      clip_out <= s2_clip | l_sat[W] | r_sat[W];
    end
  end

  assign out_valid = v3;

endmodule

/* hw/rtl/swpr_pan.sv */
// pan stage: per-channel gain from the position, multiply, floor and saturate
module swpr_pan #(
  parameter int W = swpr_pkg::SAMPLE_BITS_DEF + swpr_pkg::GUARD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [W-1:0]          a_in,
  input  logic signed [W-1:0]          b_in,
  input  logic                         clip_in,
  input  logic [swpr_pkg::POS_W-1:0]   position,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [W-1:0]          a_out,
  output logic signed [W-1:0]          b_out,
  output logic                         clip_out
);

  localparam int PN  = swpr_pkg::POS_W;
  localparam int PW  = W + PN;
  localparam int EXT = W + 2;

  function automatic logic [W:0] sat_ext(input logic signed [EXT-1:0] x);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &x[EXT-1:W-1];
    hi_zeros = ~|x[EXT-1:W-1];
    if (hi_ones || hi_zeros) begin
      sat_ext = {1'b0, x[W-1:0]};
    end else begin
      sat_ext = {1'b1, x[EXT-1], {(W-1){~x[EXT-1]}}};
    end
  endfunction

  logic v1, v2;
  logic ready1, ready2;

  assign ready2   = !v2 || out_ready;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1;

  // left gain is one minus the positive part, right gain one plus the negative part
  logic signed [PN:0]   p_ext, gl_w, gr_w;
  logic signed [PN-1:0] gain_l, gain_r;

  always_comb begin
    p_ext  = {position[PN-1], position};
    gl_w   = (PN+1)'(swpr_pkg::POS_ONE) - (position[PN-1] ? '0 : p_ext);
    gr_w   = (PN+1)'(swpr_pkg::POS_ONE) + (position[PN-1] ? p_ext : '0);
    gain_l = gl_w[PN-1:0];
    gain_r = gr_w[PN-1:0];
  end

  logic signed [PW-1:0]  prod_l, prod_r;
  logic signed [EXT-1:0] s1_l, s1_r;
  logic                  s1_clip;
  logic [W:0]            l_sat, r_sat;

  always_comb begin
    prod_l = a_in * gain_l;
    prod_r = b_in * gain_r;
    l_sat  = sat_ext(s1_l);
    r_sat  = sat_ext(s1_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (ready1) v1 <= in_valid;
      if (ready2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      s1_l    <= EXT'(prod_l >>> swpr_pkg::POS_FRAC);
      s1_r    <= EXT'(prod_r >>> swpr_pkg::POS_FRAC);
      s1_clip <= clip_in;
    end
    if (ready2 && v1) begin
      a_out    <= l_sat[W-1:0];
      b_out    <= r_sat[W-1:0];
      clip_out <= s1_clip | l_sat[W] | r_sat[W];
    end
  end

  assign out_valid = v2;

endmodule

/* hw/rtl/stereo_width_pan_rotate_mixer.sv */
// stereo imager top level: register file, processing chain and output saturation
//
// Stereo frames enter on the input channel (in_valid, in_stall, left_in, right_in)
// and leave on the output channel (out_valid, out_stall, left_out, right_out, clipped).
// A frame is taken at a clock edge where valid is high and stall is low.
// Chain: mid/side width, pan, rotation, pan, mid/side width with volume,
// then saturation to the sample width; clipped flags any saturation on the way.
// Register stages in order: sum/difference, gain product and recombine in each width
// stage, product and saturate in each pan stage, products and combine in the rotation, then the output register.
// Throughput is one frame per cycle while no stage stalls; every multiply has its own register stage.
// Each stage holds its frame while the next is full, so empty stages fill up while
// the receiver stalls and in_stall rises only once the whole pipeline is full.
// Reset (rst, synchronous) empties the pipeline and loads the register defaults:
// mid gains of one half, side gains of one, centered pans, zero rotation.
// The user must write registers over the APB port only while no frame is in flight;
// the block does not enforce this. They sit at byte addresses 0, 4, .. 28 in the order
// mid1_gain, side1_gain, pan1_position, rot_cos, rot_sin, pan2_position, mid2_gain, side2_gain.
module stereo_width_pan_rotate_mixer #(
  parameter int SAMPLE_BITS = swpr_pkg::SAMPLE_BITS_DEF,
  parameter int GUARD_BITS  = swpr_pkg::GUARD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swpr_pkg::ADDR_W-1:0]   paddr,
  input  logic [swpr_pkg::DATA_W-1:0]   pwdata,
  output logic [swpr_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] left_in,
  input  logic signed [SAMPLE_BITS-1:0] right_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] left_out,
  output logic signed [SAMPLE_BITS-1:0] right_out,
  output logic                          clipped
);

  localparam int W    = SAMPLE_BITS + GUARD_BITS;
  localparam int GW   = swpr_pkg::GAIN_W;
  localparam int PN   = swpr_pkg::POS_W;
  localparam int CN   = swpr_pkg::COS_W;
  localparam int DW   = swpr_pkg::DATA_W;
  localparam int RPW  = W + PN;
  localparam int REXT = W + 3;

  // register file
  logic [GW-1:0] mid1_gain, side1_gain, mid2_gain, side2_gain;
  logic [PN-1:0] pan1_position, pan2_position, rot_sin;
  logic [CN-1:0] rot_cos;
  swpr_pkg::reg_index_t reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = swpr_pkg::reg_index_t'(paddr[swpr_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      mid1_gain     <= swpr_pkg::MID_GAIN_RST;
      side1_gain    <= swpr_pkg::SIDE_GAIN_RST;
      pan1_position <= swpr_pkg::PAN_RST;
      rot_cos       <= swpr_pkg::COS_RST;
      rot_sin       <= swpr_pkg::SIN_RST;
      pan2_position <= swpr_pkg::PAN_RST;
      mid2_gain     <= swpr_pkg::MID_GAIN_RST;
      side2_gain    <= swpr_pkg::SIDE_GAIN_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        swpr_pkg::REG_MID1:  mid1_gain     <= pwdata[GW-1:0];
        swpr_pkg::REG_SIDE1: side1_gain    <= pwdata[GW-1:0];
        swpr_pkg::REG_PAN1:  pan1_position <= pwdata[PN-1:0];
        swpr_pkg::REG_COS:   rot_cos       <= pwdata[CN-1:0];
        swpr_pkg::REG_SIN:   rot_sin       <= pwdata[PN-1:0];
        swpr_pkg::REG_PAN2:  pan2_position <= pwdata[PN-1:0];
        swpr_pkg::REG_MID2:  mid2_gain     <= pwdata[GW-1:0];
        swpr_pkg::REG_SIDE2: side2_gain    <= pwdata[GW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      swpr_pkg::REG_MID1:  prdata = {{(DW-GW){1'b0}}, mid1_gain};
      swpr_pkg::REG_SIDE1: prdata = {{(DW-GW){1'b0}}, side1_gain};
      swpr_pkg::REG_PAN1:  prdata = {{(DW-PN){1'b0}}, pan1_position};
      swpr_pkg::REG_COS:   prdata = {{(DW-CN){1'b0}}, rot_cos};
      swpr_pkg::REG_SIN:   prdata = {{(DW-PN){1'b0}}, rot_sin};
      swpr_pkg::REG_PAN2:  prdata = {{(DW-PN){1'b0}}, pan2_position};
      swpr_pkg::REG_MID2:  prdata = {{(DW-GW){1'b0}}, mid2_gain};
      swpr_pkg::REG_SIDE2: prdata = {{(DW-GW){1'b0}}, side2_gain};
      default:             prdata = '0;
    endcase
  end

  // input widening
  logic signed [W-1:0] l_in_w, r_in_w;
  assign l_in_w = {{GUARD_BITS{left_in[SAMPLE_BITS-1]}}, left_in};
  assign r_in_w = {{GUARD_BITS{right_in[SAMPLE_BITS-1]}}, right_in};

  // width stage 1
  logic                w1_in_ready, w1_valid, w1_ready, w1_clip;
  logic signed [W-1:0] w1_a, w1_b;

  assign in_stall = !w1_in_ready;

  swpr_width #(.W(W)) u_width1 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (w1_in_ready),
    .a_in      (l_in_w),
    .b_in      (r_in_w),
    .clip_in   (1'b0),
    .mid_gain  (mid1_gain),
    .side_gain (side1_gain),
    .out_valid (w1_valid),
    .out_ready (w1_ready),
    .a_out     (w1_a),
    .b_out     (w1_b),
    .clip_out  (w1_clip)
  );

  // pan 1
  logic                p1_valid, p1_ready, p1_clip;
  logic signed [W-1:0] p1_a, p1_b;

  swpr_pan #(.W(W)) u_pan1 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (w1_valid),
    .in_ready  (w1_ready),
    .a_in      (w1_a),
    .b_in      (w1_b),
    .clip_in   (w1_clip),
    .position  (pan1_position),
    .out_valid (p1_valid),
    .out_ready (p1_ready),
    .a_out     (p1_a),
    .b_out     (p1_b),
    .clip_out  (p1_clip)
  );

  // rotation: products in one stage, combine, floor and saturate in the next
  function automatic logic [W:0] sat_rot(input logic signed [REXT-1:0] x);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &x[REXT-1:W-1];
    hi_zeros = ~|x[REXT-1:W-1];
    if (hi_ones || hi_zeros) begin
      sat_rot = {1'b0, x[W-1:0]};
    end else begin
      sat_rot = {1'b1, x[REXT-1], {(W-1){~x[REXT-1]}}};
    end
  endfunction

  logic                 rv1, rv2, r1_ready, r2_ready, p2_in_ready;
  logic signed [RPW-1:0] prod_lc, prod_rs, prod_rc, prod_ls;
  logic signed [RPW-1:0] r1_lc, r1_rs, r1_rc, r1_ls;
  logic                  r1_clip;
  logic signed [RPW:0]   rot_l_full, rot_r_full;
  logic signed [REXT-1:0] rot_l_sh, rot_r_sh;
  logic [W:0]            rot_l_sat, rot_r_sat;
  logic signed [W-1:0]   r2_a, r2_b;
  logic                  r2_clip;
  logic signed [PN-1:0]  sin_s, cos_s;

  assign r2_ready = !rv2 || p2_in_ready;
  assign r1_ready = !rv1 || r2_ready;
  assign p1_ready = r1_ready;

  always_comb begin
    cos_s      = $signed({1'b0, rot_cos});
    sin_s      = $signed(rot_sin);
    prod_lc    = p1_a * cos_s;
    prod_rs    = p1_b * sin_s;
    prod_rc    = p1_b * cos_s;
    prod_ls    = p1_a * sin_s;
    rot_l_full = {r1_lc[RPW-1], r1_lc} - {r1_rs[RPW-1], r1_rs};
    rot_r_full = {r1_rc[RPW-1], r1_rc} + {r1_ls[RPW-1], r1_ls};
    rot_l_sh   = REXT'(rot_l_full >>> swpr_pkg::POS_FRAC);
    rot_r_sh   = REXT'(rot_r_full >>> swpr_pkg::POS_FRAC);
    rot_l_sat  = sat_rot(rot_l_sh);
    rot_r_sat  = sat_rot(rot_r_sh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rv1 <= 1'b0;
      rv2 <= 1'b0;
    end else begin
      if (r1_ready) rv1 <= p1_valid;
      if (r2_ready) rv2 <= rv1;
    end
  end

  always_ff @(posedge clk) begin
    if (r1_ready && p1_valid) begin
      r1_lc   <= prod_lc;
      r1_rs   <= prod_rs;
      r1_rc   <= prod_rc;
      r1_ls   <= prod_ls;
      r1_clip <= p1_clip;
    end
    if (r2_ready && rv1) begin
      r2_a    <= rot_l_sat[W-1:0];
      r2_b    <= rot_r_sat[W-1:0];
      r2_clip <= r1_clip | rot_l_sat[W] | rot_r_sat[W];
    end
  end

  // pan 2
  logic                p2_valid, p2_ready, p2_clip;
  logic signed [W-1:0] p2_a, p2_b;

  swpr_pan #(.W(W)) u_pan2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rv2),
    .in_ready  (p2_in_ready),
    .a_in      (r2_a),
    .b_in      (r2_b),
    .clip_in   (r2_clip),
    .position  (pan2_position),
    .out_valid (p2_valid),
    .out_ready (p2_ready),
    .a_out     (p2_a),
    .b_out     (p2_b),
    .clip_out  (p2_clip)
  );

  // width stage 2 with output volume
  logic                w2_valid, w2_ready, w2_clip;
  logic signed [W-1:0] w2_a, w2_b;

  swpr_width #(.W(W)) u_width2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p2_valid),
    .in_ready  (p2_ready),
    .a_in      (p2_a),
    .b_in      (p2_b),
    .clip_in   (p2_clip),
    .mid_gain  (mid2_gain),
    .side_gain (side2_gain),
    .out_valid (w2_valid),
    .out_ready (w2_ready),
    .a_out     (w2_a),
    .b_out     (w2_b),
    .clip_out  (w2_clip)
  );

  // output saturation to sample width
  function automatic logic [SAMPLE_BITS:0] sat_out(input logic signed [W-1:0] x);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &x[W-1:SAMPLE_BITS-1];
    hi_zeros = ~|x[W-1:SAMPLE_BITS-1];
    if (hi_ones || hi_zeros) begin
      sat_out = {1'b0, x[SAMPLE_BITS-1:0]};
    end else begin
      sat_out = {1'b1, x[W-1], {(SAMPLE_BITS-1){~x[W-1]}}};
    end
  endfunction

  logic                 ov, o_ready;
  logic [SAMPLE_BITS:0] l_fin, r_fin;

  assign o_ready  = !ov || !out_stall;
  assign w2_ready = o_ready;
  assign l_fin    = sat_out(w2_a);
  assign r_fin    = sat_out(w2_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (o_ready) begin
      ov <= w2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && w2_valid) begin
      left_out  <= l_fin[SAMPLE_BITS-1:0];
      right_out <= r_fin[SAMPLE_BITS-1:0];
      clipped   <= w2_clip | l_fin[SAMPLE_BITS] | r_fin[SAMPLE_BITS];
    end
  end

  assign out_valid = ov;

endmodule

/* test/stereo_image_checker.sv */
`timescale 1ns / 100ps
// checker for the stereo imager: watches both channels and the register port, predicts frames
module stereo_image_checker #(
  parameter int SB = swpr_pkg::SAMPLE_BITS_DEF,
  parameter int GB = swpr_pkg::GUARD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [swpr_pkg::ADDR_W-1:0] paddr,
  input  logic [swpr_pkg::DATA_W-1:0] pwdata,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic signed [SB-1:0]        left_in,
  input  logic signed [SB-1:0]        right_in,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic signed [SB-1:0]        left_out,
  input  logic signed [SB-1:0]        right_out,
  input  logic                        clipped,
  output int                          pending,
  output int                          errors
);

  localparam int WB = SB + GB;
  localparam int MAX_REPORTS = 200;

  typedef struct {
    logic signed [SB-1:0] left;
    logic signed [SB-1:0] right;
    logic                 clip;
  } frame_t;

  logic [swpr_pkg::GAIN_W-1:0] mid1_g, side1_g, mid2_g, side2_g;
  logic [swpr_pkg::POS_W-1:0]  pan1_p, pan2_p, sin_v;
  logic [swpr_pkg::COS_W-1:0]  cos_v;

  frame_t expected_frames[$];
  frame_t want;
  int     fail_count = 0;
  int     in_flight = 0;

  assign pending = in_flight;
  assign errors  = fail_count;

  function automatic longint clamp(input longint x, input int bits, inout bit hit);
    longint hi, lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (x < lo) begin
      hit = 1'b1;
      return lo;
    end
    return x;
  endfunction

  function automatic void mid_side(inout longint a, inout longint b,
                                   input logic [swpr_pkg::GAIN_W-1:0] mg,
                                   input logic [swpr_pkg::GAIN_W-1:0] sg,
                                   inout bit hit);
    longint sum, dif, m, d, mgl, sgl;
    mgl = longint'(mg);
    sgl = longint'(sg);
    sum = clamp(a + b, WB, hit);
    dif = clamp(a - b, WB, hit);
    m = (sum * mgl) >>> swpr_pkg::GAIN_FRAC;
    d = (dif * sgl) >>> swpr_pkg::GAIN_FRAC;
    a = clamp(m + d, WB, hit);
    b = clamp(m - d, WB, hit);
  endfunction

  function automatic void pan(inout longint a, inout longint b,
                              input logic [swpr_pkg::POS_W-1:0] pos, inout bit hit);
    longint p, gl, gr;
    p = longint'($signed(pos));
    gl = swpr_pkg::POS_ONE - ((p > 0) ? p : 0);
    gr = swpr_pkg::POS_ONE + ((p < 0) ? p : 0);
    a = clamp((a * gl) >>> swpr_pkg::POS_FRAC, WB, hit);
    b = clamp((b * gr) >>> swpr_pkg::POS_FRAC, WB, hit);
  endfunction

  function automatic frame_t image_frame(input logic signed [SB-1:0] li,
                                         input logic signed [SB-1:0] ri);
    longint l, r, c, s, nl, nr;
    bit     hit;
    frame_t f;
    hit = 1'b0;
    l = longint'(li);
    r = longint'(ri);
    c = longint'(cos_v);
    s = longint'($signed(sin_v));
    mid_side(l, r, mid1_g, side1_g, hit);
    pan(l, r, pan1_p, hit);
    nl = (l * c - r * s) >>> swpr_pkg::POS_FRAC;
    nr = (r * c + l * s) >>> swpr_pkg::POS_FRAC;
    l = clamp(nl, WB, hit);
    r = clamp(nr, WB, hit);
    pan(l, r, pan2_p, hit);
    mid_side(l, r, mid2_g, side2_g, hit);
    f.left  = SB'(clamp(l, SB, hit));
    f.right = SB'(clamp(r, SB, hit));
    f.clip  = hit;
    return f;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      expected_frames.delete();
      mid1_g  = swpr_pkg::MID_GAIN_RST;
      side1_g = swpr_pkg::SIDE_GAIN_RST;
      mid2_g  = swpr_pkg::MID_GAIN_RST;
      side2_g = swpr_pkg::SIDE_GAIN_RST;
      pan1_p  = swpr_pkg::PAN_RST;
      pan2_p  = swpr_pkg::PAN_RST;
      cos_v   = swpr_pkg::COS_RST;
      sin_v   = swpr_pkg::SIN_RST;
    end else begin
      if (in_valid && !in_stall) begin
        expected_frames.push_back(image_frame(left_in, right_in));
      end
      if (out_valid && !out_stall) begin
        if (expected_frames.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("%0t: unexpected transaction: left %0d right %0d clipped %0b",
                     $time, left_out, right_out, clipped);
          end
        end else begin
          want = expected_frames.pop_front();
          if (left_out !== want.left || right_out !== want.right ||
              clipped !== want.clip) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display({"%0t: mismatch: expected left %0d right %0d clipped %0b,",
                        " got left %0d right %0d clipped %0b"},
                       $time, want.left, want.right, want.clip,
                       left_out, right_out, clipped);
            end
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (swpr_pkg::reg_index_t'(paddr[swpr_pkg::ADDR_W-1:2]))
          swpr_pkg::REG_MID1:  mid1_g  = pwdata[swpr_pkg::GAIN_W-1:0];
          swpr_pkg::REG_SIDE1: side1_g = pwdata[swpr_pkg::GAIN_W-1:0];
          swpr_pkg::REG_PAN1:  pan1_p  = pwdata[swpr_pkg::POS_W-1:0];
          swpr_pkg::REG_COS:   cos_v   = pwdata[swpr_pkg::COS_W-1:0];
          swpr_pkg::REG_SIN:   sin_v   = pwdata[swpr_pkg::POS_W-1:0];
          swpr_pkg::REG_PAN2:  pan2_p  = pwdata[swpr_pkg::POS_W-1:0];
          swpr_pkg::REG_MID2:  mid2_g  = pwdata[swpr_pkg::GAIN_W-1:0];
          swpr_pkg::REG_SIDE2: side2_g = pwdata[swpr_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end
    end
    in_flight = expected_frames.size();
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// testbench top for the stereo imager: clock, reset, stimulus, register setup and verdict
module tb;

  localparam int SB = swpr_pkg::SAMPLE_BITS_DEF;
  localparam int LATENCY = 13;
  localparam int PHASES = 12;
  localparam int ITEMS_PER_PHASE = 120;
  localparam int HOLD_PHASE = 5;
  localparam int PAUSE_PHASE = 7;
  localparam int LONG_HOLD = 80;
  localparam logic [SB-1:0] SMAX = 24'h7FFFFF;
  localparam logic [SB-1:0] SMIN = 24'h800000;
  localparam logic [SB-1:0] CORNER [5] = '{24'h7FFFFF, 24'h800000, 24'h000000,
                                          24'h000001, 24'hFFFFFF};

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [swpr_pkg::ADDR_W-1:0] paddr = '0;
  logic [swpr_pkg::DATA_W-1:0] pwdata = '0;
  logic [swpr_pkg::DATA_W-1:0] prdata;
  logic                        pready;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [SB-1:0]               left_in = '0;
  logic [SB-1:0]               right_in = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [SB-1:0]               left_out;
  logic [SB-1:0]               right_out;
  logic                        clipped;

  int pending;
  int errors;
  int frames_sent = 0;
  int settings_used = 1;
  bit tx_idling = 1'b1;
  bit rx_idling = 1'b1;
  bit hold_request = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  stereo_width_pan_rotate_mixer dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .left_in, .right_in,
    .out_valid, .out_stall, .left_out, .right_out, .clipped
  );

  stereo_image_checker checker_i (
    .clk, .rst, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .in_valid, .in_stall, .left_in, .right_in,
    .out_valid, .out_stall, .left_out, .right_out, .clipped,
    .pending, .errors
  );

  function automatic logic [SB-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return SMAX;
      1: return SMIN;
      2, 3: return SB'($urandom_range(0, 8191) - 4096);
      4, 5: return SB'($urandom_range(0, 2 ** 21) - 2 ** 20);
      default: return SB'($urandom());
    endcase
  endfunction

  function automatic logic [31:0] rand_gain();
    return ($urandom_range(0, 3) == 0) ? $urandom()
                                       : $urandom_range(0, 3 << swpr_pkg::GAIN_FRAC);
  endfunction

  function automatic logic [31:0] rand_pos();
    return ($urandom_range(0, 3) == 0) ? $urandom()
                                       : $urandom_range(0, 2 * swpr_pkg::POS_ONE)
                                         - swpr_pkg::POS_ONE;
  endfunction

  task automatic offer_frame(input logic [SB-1:0] l, input logic [SB-1:0] r);
    in_valid <= 1'b1;
    left_in  <= l;
    right_in <= r;
    do @(posedge clk); while (in_stall);
    frames_sent++;
    @(negedge clk);
    if (tx_idling && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_reg(input swpr_pkg::reg_index_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
  endtask

  task automatic set_all(input logic [31:0] m1, input logic [31:0] s1, input logic [31:0] p1,
                         input logic [31:0] c, input logic [31:0] s,
                         input logic [31:0] p2, input logic [31:0] m2, input logic [31:0] s2);
    write_reg(swpr_pkg::REG_MID1, m1);
    write_reg(swpr_pkg::REG_SIDE1, s1);
    write_reg(swpr_pkg::REG_PAN1, p1);
    write_reg(swpr_pkg::REG_COS, c);
    write_reg(swpr_pkg::REG_SIN, s);
    write_reg(swpr_pkg::REG_PAN2, p2);
    write_reg(swpr_pkg::REG_MID2, m2);
    write_reg(swpr_pkg::REG_SIDE2, s2);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    settings_used++;
  endtask

  initial begin
    @(negedge clk);
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_request = 1'b0;
      end else if (rx_idling && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (CORNER[i]) begin
      foreach (CORNER[j]) begin
        offer_frame(CORNER[i], CORNER[j]);
      end
    end
    drain();
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_all(0, 0, -swpr_pkg::POS_ONE, 0, -swpr_pkg::POS_ONE, -swpr_pkg::POS_ONE,
                   0, 0);
        1: set_all(32'hFFFFFF, 32'hFFFFFF, swpr_pkg::POS_ONE, swpr_pkg::POS_ONE,
                   swpr_pkg::POS_ONE, swpr_pkg::POS_ONE, 32'hFFFFFF, 32'hFFFFFF);
        // raw register limits: pan1 beyond plus one, sine and pan2 beyond minus one, cosine beyond one
        2: set_all(rand_gain(), rand_gain(), 32'h1FFFF, 32'h1FFFF, 32'h20000, 32'h20000,
                   rand_gain(), rand_gain());
        3: set_all(32'd524288, 32'd524288, 0, swpr_pkg::POS_ONE, 0, 0,
                   32'd524288, 32'd524288);
        default: set_all(rand_gain(), rand_gain(), rand_pos(),
                         ($urandom_range(0, 3) == 0) ? $urandom()
                                                     : $urandom_range(0, swpr_pkg::POS_ONE),
                         rand_pos(), rand_pos(), rand_gain(), rand_gain());
      endcase
      tx_idling = (ph != PHASES - 1) && ($urandom_range(0, 2) != 0);
      rx_idling = (ph != PHASES - 1) && ($urandom_range(0, 2) != 0);
      if (ph == HOLD_PHASE) begin
        tx_idling = 1'b0;
        hold_request = 1'b1;
      end
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (ph == PAUSE_PHASE && k == ITEMS_PER_PHASE / 2) begin
          drain();
        end
        offer_frame(rand_sample(), rand_sample());
      end
      drain();
    end
    $display("streamed %0d stereo frames over %0d register settings", frames_sent,
             settings_used);
    $display("included corner samples, range-limit registers, stalls and a long output hold");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d frames still expected", pending);
    $display("== FAIL ==");
    $finish;
  end

endmodule
